[design/asdl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdl_pkg
// Shared types, codes and helper functions of the aux strobe display latch.
// ----------------------------------------------------------------------------
package asdl_pkg;

  localparam int LED2_COLUMNS = 32;
  localparam int MAX_RES      = 5;
  localparam int CNT_W        = $clog2(MAX_RES + 1);
  localparam int SHIFT_DEPTH  = 7;

  localparam logic [1:0] REQ_AUX    = 2'd0;
  localparam logic [1:0] REQ_STROBE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] KIND_DOT  = 2'd0;
  localparam logic [1:0] KIND_LAMP = 2'd1;
  localparam logic [1:0] KIND_SOL  = 2'd2;
  localparam logic [1:0] KIND_READ = 2'd3;

  localparam logic [2:0] MODE_AUX  = 3'd0;
  localparam logic [2:0] MODE_T1   = 3'd1;
  localparam logic [2:0] MODE_T1S  = 3'd2;
  localparam logic [2:0] MODE_T2   = 3'd3;
  localparam logic [2:0] MODE_LED  = 3'd4;
  localparam logic [2:0] MODE_LED2 = 3'd5;

  localparam logic [7:0] STROBE_SOL  = 8'hbe;
  localparam logic [7:0] STROBE_LAMP = 8'h7e;
  localparam logic [7:0] AUX_RESYNC  = 8'h30;
  localparam logic [7:0] READ_IDLE   = 8'h40;

  localparam logic [2:0] LED_SLOT [7] = '{3'd6, 3'd2, 3'd4, 3'd5, 3'd1, 3'd3, 3'd0};

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] plane;
    logic [1:0] group;
    logic [2:0] column;
    logic [5:0] lamp_column;
    logic [7:0] value;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] item;
    logic [CNT_W-1:0]   count;
  } batch_t;

  function automatic res_t mk_res(logic [1:0] kind, logic [1:0] plane, logic [1:0] group,
                                  logic [2:0] column, logic [5:0] lamp, logic [7:0] value);
    res_t r;
    r.kind        = kind;
    r.plane       = plane;
    r.group       = group;
    r.column      = column;
    r.lamp_column = lamp;
    r.value       = value;
    return r;
  endfunction

  // index of highest set bit
  function automatic logic [2:0] hi_bit5(logic [4:0] v);
    logic [2:0] c;
    c = 3'd0;
    for (int i = 0; i < 5; i++) begin
      if (v[i]) c = 3'(i);
    end
    return c;
  endfunction

  // index of lowest set bit
  function automatic logic [2:0] lo_bit7(logic [6:0] v);
    logic [2:0] c;
    c = 3'd0;
    for (int i = 6; i >= 0; i--) begin
      if (v[i]) c = 3'(i);
    end
    return c;
  endfunction

  function automatic logic [2:0] mod7(logic [5:0] v);
    logic [5:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (r >= 6'd7) r = r - 6'd7;
    end
    return r[2:0];
  endfunction

  function automatic logic [4:0] led2_next(logic [4:0] bi);
    logic [5:0] r;
    r = {1'b0, bi} + 6'd1;
    if (r >= 6'(LED2_COLUMNS)) r = r - 6'(LED2_COLUMNS);
    if (r >= 6'(LED2_COLUMNS)) r = r - 6'(LED2_COLUMNS);
    return r[4:0];
  endfunction

  function automatic logic [1:0] frame_next(logic [1:0] f);
    logic [1:0] r;
    case (f)
      2'd0: r = 2'd1;
      2'd1: r = 2'd2;
      2'd2: r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

[design/aux_strobe_display_latch.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aux_strobe_display_latch
// Aux output port with strobe decoding for mini dot displays and lamp/LED
// columns.
// ----------------------------------------------------------------------------
// A request transaction is registered, decoded combinationally against the
// port state and handed as a batch of zero to five result writes to the
// output buffer, which sends them one per cycle while the output is ready.
// Requests with at most one result run at one per cycle while the output is
// ready; the request after one with more results is held until the single
// output buffer sends the last of them, and is taken in that same cycle.
module aux_strobe_display_latch import asdl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,  // display_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // data
  input  logic [1:0]  s_tuser,      // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,      // plane, group, column, lamp_column, value, zero pad
  output logic [1:0]  m_tuser,      // kind
  output logic        m_tlast
);

  logic       in_valid;
  logic [1:0] in_req;
  logic [7:0] in_data;
  logic       adv;
  logic       load_ready;
  batch_t     batch;
  res_t       out_res;

  assign adv      = in_valid && load_ready;
  assign s_tready = !in_valid || load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req  <= s_tuser;
      in_data <= s_tdata;
    end
  end

  asdl_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .adv         (adv),
    .req         (in_req),
    .din         (in_data),
    .batch       (batch)
  );

  asdl_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_valid (in_valid),
    .load_ready (load_ready),
    .batch      (batch),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_last   (m_tlast),
    .out_res    (out_res)
  );

  assign m_tuser = out_res.kind;
  assign m_tdata = {3'd0, out_res.value, out_res.lamp_column, out_res.column,
                    out_res.group, out_res.plane};

endmodule

[design/asdl_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdl_core
// Decoder state and the per-request decode into a batch of result writes.
// ----------------------------------------------------------------------------
module asdl_core import asdl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  input  logic       adv,
  input  logic [1:0] req,
  input  logic [7:0] din,
  output batch_t     batch
);

  logic [2:0] display_mode;
  logic [7:0] aux_latch, aux_latch_next;
  logic [7:0] last_strobe, last_strobe_next;
  logic [6:0] shift_bytes [SHIFT_DEPTH];
  logic [6:0] shift_bytes_next [SHIFT_DEPTH];
  logic [4:0] byte_index, byte_index_next;
  logic [1:0] frame_index, frame_index_next;

  logic       rise;
  logic [6:0] aux7;
  logic [1:0] t1_idx;
  logic [4:0] t1_sel;
  logic [6:0] t1_d0, t1_d1;
  logic [2:0] t2_idx;
  logic [6:0] t2_sb [SHIFT_DEPTH];
  logic [4:0] led_bi;
  logic [4:0] led2_bi;

  assign rise   = din[7] & ~last_strobe[7];
  assign aux7   = aux_latch[6:0];
  assign t1_idx = byte_index[1:0];
  assign t2_idx = mod7({1'b0, byte_index} + 6'd1);
  assign led_bi = (aux_latch == AUX_RESYNC && last_strobe[6]) ? 5'd0 : byte_index;
  assign led2_bi = led2_next(byte_index);

  // ring taps relative to the write slot
  always_comb begin
    case (t1_idx)
      2'd0: begin
        t1_sel = shift_bytes[1][4:0];
        t1_d0  = shift_bytes[2];
        t1_d1  = shift_bytes[3];
      end
      2'd1: begin
        t1_sel = shift_bytes[2][4:0];
        t1_d0  = shift_bytes[3];
        t1_d1  = shift_bytes[0];
      end
      2'd2: begin
        t1_sel = shift_bytes[3][4:0];
        t1_d0  = shift_bytes[0];
        t1_d1  = shift_bytes[1];
      end
      default: begin
        t1_sel = shift_bytes[0][4:0];
        t1_d0  = shift_bytes[1];
        t1_d1  = shift_bytes[2];
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < SHIFT_DEPTH; k++) begin
      t2_sb[k] = (t2_idx == 3'(k)) ? aux7 : shift_bytes[k];
    end
  end

  always_comb begin
    logic [2:0] n;
    logic [2:0] col;
    logic [1:0] grp;
    logic [2:0] slot;
    n                = 3'd0;
    col              = 3'd0;
    grp              = 2'd0;
    slot             = 3'd0;
    batch            = '0;
    aux_latch_next   = aux_latch;
    last_strobe_next = last_strobe;
    byte_index_next  = byte_index;
    frame_index_next = frame_index;
    shift_bytes_next = shift_bytes;
    case (req)
      REQ_AUX: begin
        aux_latch_next = din;
      end
      REQ_STROBE: begin
        case (display_mode)
          MODE_T1, MODE_T1S: begin
            if (rise) begin
              shift_bytes_next[t1_idx] = aux7;
              byte_index_next = {3'd0, t1_idx + 2'd1};
              if (!aux_latch[7] && t1_sel != 5'd0) begin
                col = hi_bit5(t1_sel);
                batch.item[0] = mk_res(KIND_DOT, frame_index, 2'd0, col, 6'd0, {1'b0, t1_d0});
                batch.item[1] = mk_res(KIND_DOT, frame_index, 2'd1, col, 6'd0, {1'b0, t1_d1});
                batch.item[2] = mk_res(KIND_DOT, frame_index, 2'd2, col, 6'd0, {1'b0, aux7});
                n = 3'd3;
                if (col == 3'd4) frame_index_next = frame_next(frame_index);
              end
            end
            if (display_mode == MODE_T1S) begin
              if (din == STROBE_SOL) begin
                batch.item[n] = mk_res(KIND_SOL, 2'd0, 2'd0, 3'd0, 6'd0, aux_latch);
                n = n + 3'd1;
              end
            end else begin
              batch.item[n] = mk_res(KIND_SOL, 2'd0, 2'd0, 3'd0, 6'd0, {5'd0, din[5:3]});
              n = n + 3'd1;
            end
            last_strobe_next = din;
          end
          MODE_T2: begin
            if (rise) begin
              byte_index_next = {2'd0, t2_idx};
              shift_bytes_next[t2_idx] = aux7;
              if (!aux_latch[7] && (t2_sb[4] != 7'd0 || t2_sb[3] != 7'd0)) begin
                if (t2_sb[4] != 7'd0) begin
                  grp = 2'd0;
                  col = lo_bit7(t2_sb[4]);
                end else begin
                  grp = 2'd1;
                  col = lo_bit7(t2_sb[3]);
                end
                batch.item[0] = mk_res(KIND_DOT, 2'd0, grp, col, 6'd0, {1'b0, t2_sb[0]});
                batch.item[1] = mk_res(KIND_DOT, 2'd1, grp, col, 6'd0, {1'b0, t2_sb[1]});
                batch.item[2] = mk_res(KIND_DOT, 2'd2, grp, col, 6'd0, {1'b0, t2_sb[5]});
                batch.item[3] = mk_res(KIND_DOT, 2'd3, grp, col, 6'd0, {1'b0, t2_sb[6]});
                n = 3'd4;
              end
            end
            if (din == STROBE_SOL) begin
              batch.item[n] = mk_res(KIND_SOL, 2'd0, 2'd0, 3'd0, 6'd0, aux_latch);
              n = n + 3'd1;
            end
            last_strobe_next = din;
          end
          MODE_LED: begin
            byte_index_next = led_bi;
            if (din == STROBE_LAMP) begin
              if (led_bi < 5'd7) begin
                slot = LED_SLOT[led_bi[2:0]];
                if (slot != 3'd0) begin
                  batch.item[0] = mk_res(KIND_LAMP, 2'd0, 2'd0, 3'd0,
                                         {3'd0, slot} + 6'd9, aux_latch);
                  n = 3'd1;
                end
                if (led_bi < 5'd6) byte_index_next = led_bi + 5'd1;
              end
            end else if (din == STROBE_SOL) begin
              batch.item[0] = mk_res(KIND_SOL, 2'd0, 2'd0, 3'd0, 6'd0, aux_latch);
              n = 3'd1;
            end
            last_strobe_next = aux_latch;
          end
          MODE_LED2: begin
            if (rise) begin
              byte_index_next = led2_bi;
              batch.item[0] = mk_res(KIND_LAMP, 2'd0, 2'd0, 3'd0,
                                     {1'b0, led2_bi} + 6'd10, aux_latch);
              n = 3'd1;
            end
            last_strobe_next = din;
          end
          default: begin
            batch.item[0] = mk_res(KIND_SOL, 2'd0, 2'd0, 3'd0, 6'd0, aux_latch);
            n = 3'd1;
          end
        endcase
      end
      REQ_READ: begin
        batch.item[0] = mk_res(KIND_READ, 2'd0, 2'd0, 3'd0, 6'd0,
                               last_strobe[5] ? aux_latch : READ_IDLE);
        n = 3'd1;
      end
      default: begin
      end
    endcase
    batch.count = CNT_W'(n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode <= MODE_AUX;
      aux_latch    <= 8'd0;
      last_strobe  <= 8'd0;
      byte_index   <= 5'd0;
      frame_index  <= 2'd0;
      for (int k = 0; k < SHIFT_DEPTH; k++) shift_bytes[k] <= 7'd0;
    end else if (cfg_wr_en) begin
      display_mode <= cfg_wr_data;
      byte_index   <= (cfg_wr_data == MODE_LED2) ? 5'd1 : 5'd0;
    end else if (adv) begin
      aux_latch   <= aux_latch_next;
      last_strobe <= last_strobe_next;
      byte_index  <= byte_index_next;
      frame_index <= frame_index_next;
      shift_bytes <= shift_bytes_next;
    end
  end

endmodule

[design/asdl_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdl_emit
// Result buffer: holds one decoded batch; one write a cycle while out_ready.
// ----------------------------------------------------------------------------
module asdl_emit import asdl_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   load_valid,
  output logic   load_ready,
  input  batch_t batch,
  output logic   out_valid,
  input  logic   out_ready,
  output logic   out_last,
  output res_t   out_res
);

  res_t             res_buf [MAX_RES];
  logic [CNT_W-1:0] remain;
  logic             take;

  assign out_valid  = remain != '0;
  assign out_last   = remain == CNT_W'(1);
  assign out_res    = res_buf[0];
  assign take       = out_valid && out_ready;
  assign load_ready = !out_valid || (take && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (load_valid && load_ready) begin
      remain <= batch.count;
    end else if (take) begin
      remain <= remain - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      for (int k = 0; k < MAX_RES; k++) res_buf[k] <= batch.item[k];
    end else if (take) begin
      for (int k = 0; k < MAX_RES - 1; k++) res_buf[k] <= res_buf[k+1];
    end
  end

endmodule

[design/asdl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asdl_checker
// Port-level checks of the aux strobe display latch, bound to the top level.
// ----------------------------------------------------------------------------
module asdl_checker import asdl_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // read data and lamp writes stand alone in their transaction group
  a_read_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_READ || m_tuser == KIND_LAMP) |-> m_tlast)
    else $error("read or lamp result not last");

  // solenoid update always closes the group
  a_sol_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_SOL |-> m_tlast && m_tdata[12:0] == 13'd0)
    else $error("solenoid result misplaced");

  // a dot write carries no lamp column and a column below seven
  a_dot_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_DOT |-> m_tdata[12:7] == 6'd0 && m_tdata[6:4] != 3'd7)
    else $error("dot write address out of range");

endmodule

bind aux_strobe_display_latch asdl_checker u_asdl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the aux strobe display latch: a directed table then
// random request streams in every display mode, with random stalls on both
// sides, each result write checked against a cycle-free model of the port.
// ----------------------------------------------------------------------------
module tb;
  import asdl_pkg::*;

  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam logic [1:0] REQ_NONE    = 2'd3;
  localparam logic [7:0] STROBE_BIT  = 8'h80;
  localparam int         DRAIN_CYC   = 10;

  typedef struct packed {
    res_t w;
    logic last;
  } port_write_t;

  typedef enum logic {ROW_ITEM, ROW_MODE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  req;
    logic [7:0]  data;
    bit          known;
    port_write_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  // port model state
  logic [2:0] cur_mode;
  logic [7:0] aux_byte;
  logic [7:0] prev_strobe;
  logic [6:0] ring [SHIFT_DEPTH];
  logic [4:0] col_ptr;
  logic [1:0] frame;

  port_write_t new_writes[$];
  port_write_t pending_writes[$];
  stim_row_t   stim_rows[$];

  int errors = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;

  aux_strobe_display_latch dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("tb: done, errors");
    $finish;
  end

  task automatic add_write(input logic [1:0] kind, input logic [1:0] pl, input logic [1:0] grp,
                           input logic [2:0] col, input logic [5:0] lamp, input logic [7:0] val);
    port_write_t p;
    p.w.kind        = kind;
    p.w.plane       = pl;
    p.w.group       = grp;
    p.w.column      = col;
    p.w.lamp_column = lamp;
    p.w.value       = val;
    p.last          = 1'b0;
    new_writes.push_back(p);
  endtask

  // type 1: four-byte ring, highest set bit of the column select
  task automatic shift_type1();
    int         i;
    int         col;
    logic [4:0] sel;
    i = int'(col_ptr) % 4;
    ring[i] = aux_byte[6:0];
    i = (i + 1) % 4;
    col_ptr = 5'(i);
    if (!aux_byte[7]) begin
      sel = ring[i][4:0];
      if (sel != '0) begin
        col = 0;
        for (int k = 0; k < 5; k++) begin
          if (sel[k]) col = k;
        end
        for (int g = 0; g < 3; g++) begin
          add_write(KIND_DOT, frame, 2'(g), 3'(col), 6'd0, {1'b0, ring[(i + 1 + g) % 4]});
        end
        if (col == 4) frame = 2'((int'(frame) + 1) % 3);
      end
    end
  endtask

  // type 2: seven-byte ring, lowest set bit over 14 select bits
  task automatic shift_type2();
    int          i;
    bit          found;
    logic [13:0] sel;
    i = (int'(col_ptr) + 1) % 7;
    col_ptr = 5'(i);
    ring[i] = aux_byte[6:0];
    if (!aux_byte[7]) begin
      sel = {ring[3], ring[4]};
      found = 1'b0;
      for (int b = 0; b < 14; b++) begin
        if (sel[b] && !found) begin
          found = 1'b1;
          add_write(KIND_DOT, 2'd0, 2'(b / 7), 3'(b % 7), 6'd0, {1'b0, ring[0]});
          add_write(KIND_DOT, 2'd1, 2'(b / 7), 3'(b % 7), 6'd0, {1'b0, ring[1]});
          add_write(KIND_DOT, 2'd2, 2'(b / 7), 3'(b % 7), 6'd0, {1'b0, ring[5]});
          add_write(KIND_DOT, 2'd3, 2'(b / 7), 3'(b % 7), 6'd0, {1'b0, ring[6]});
        end
      end
    end
  endtask

  task automatic decode_request(input logic [1:0] req, input logic [7:0] d);
    bit         rise;
    logic [2:0] slot;
    rise = d[7] && !prev_strobe[7];
    if (req == REQ_AUX) begin
      aux_byte = d;
    end else if (req == REQ_READ) begin
      add_write(KIND_READ, 2'd0, 2'd0, 3'd0, 6'd0, prev_strobe[5] ? aux_byte : READ_IDLE);
    end else if (req == REQ_STROBE) begin
      case (cur_mode)
        MODE_T1, MODE_T1S: begin
          if (rise) shift_type1();
          if (cur_mode == MODE_T1S) begin
            if (d == STROBE_SOL) add_write(KIND_SOL, 2'd0, 2'd0, 3'd0, 6'd0, aux_byte);
          end else begin
            add_write(KIND_SOL, 2'd0, 2'd0, 3'd0, 6'd0, {5'd0, d[5:3]});
          end
          prev_strobe = d;
        end
        MODE_T2: begin
          if (rise) shift_type2();
          if (d == STROBE_SOL) add_write(KIND_SOL, 2'd0, 2'd0, 3'd0, 6'd0, aux_byte);
          prev_strobe = d;
        end
        MODE_LED: begin
          if (aux_byte == AUX_RESYNC && prev_strobe[6]) col_ptr = '0;
          if (d == STROBE_LAMP) begin
            if (col_ptr < 5'd7) begin
              slot = LED_SLOT[col_ptr[2:0]];
              if (slot != '0) add_write(KIND_LAMP, 2'd0, 2'd0, 3'd0, 6'(9 + slot), aux_byte);
              if (col_ptr < 5'd6) col_ptr = col_ptr + 5'd1;
            end
          end else if (d == STROBE_SOL) begin
            add_write(KIND_SOL, 2'd0, 2'd0, 3'd0, 6'd0, aux_byte);
          end
          prev_strobe = aux_byte;
        end
        MODE_LED2: begin
          if (rise) begin
            col_ptr = 5'((int'(col_ptr) + 1) % LED2_COLUMNS);
            add_write(KIND_LAMP, 2'd0, 2'd0, 3'd0, 6'(int'(col_ptr) + 10), aux_byte);
          end
          prev_strobe = d;
        end
        default: begin
          add_write(KIND_SOL, 2'd0, 2'd0, 3'd0, 6'd0, aux_byte);
        end
      endcase
    end
    if (new_writes.size() > 0) new_writes[new_writes.size() - 1].last = 1'b1;
  endtask

  task automatic send_item(input logic [1:0] req, input logic [7:0] d, input bit known,
                           input port_write_t known_res);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    new_writes.delete();
    decode_request(req, d);
    if (known) begin
      new_writes.delete();
      new_writes.push_back(known_res);
    end
    foreach (new_writes[i]) pending_writes.push_back(new_writes[i]);
  endtask

  task automatic set_mode(input logic [2:0] m);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cur_mode = m;
    col_ptr  = (m == MODE_LED2) ? 5'd1 : 5'd0;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic stim_row_t plain_row(input logic [1:0] req, input logic [7:0] d);
    stim_row_t r;
    r.kind  = ROW_ITEM;
    r.req   = req;
    r.data  = d;
    r.known = 1'b0;
    r.res   = '0;
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic [1:0] req, input logic [7:0] d,
                                          input logic [1:0] kind, input logic [5:0] lamp,
                                          input logic [7:0] val);
    stim_row_t r;
    r = plain_row(req, d);
    r.known             = 1'b1;
    r.res.w.kind        = kind;
    r.res.w.lamp_column = lamp;
    r.res.w.value       = val;
    r.res.last          = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t mode_row(input logic [2:0] m);
    stim_row_t r;
    r = plain_row(REQ_AUX, {5'd0, m});
    r.kind = ROW_MODE;
    return r;
  endfunction

  // one well-formed sequence for the mode, or a stray request
  task automatic random_burst(input logic [2:0] m, inout int sent);
    int         pick;
    logic [7:0] a;
    logic [7:0] s;
    logic [7:0] f;
    pick = $urandom_range(0, 99);
    a = 8'($urandom_range(0, 255));
    s = 8'($urandom_range(0, 255));
    f = 8'($urandom_range(0, 255));
    if (pick < 8) begin
      send_item(REQ_NONE, a, 1'b0, '0);
    end else if (pick < 18) begin
      send_item(REQ_READ, a, 1'b0, '0);
      sent++;
    end else if (pick < 28) begin
      send_item(2'($urandom_range(0, 2)), a, 1'b0, '0);
      sent++;
    end else begin
      case (m)
        MODE_T1, MODE_T1S, MODE_T2: begin
          if ($urandom_range(0, 9) != 0) a[7] = 1'b0;
          if (m != MODE_T2 && $urandom_range(0, 2) == 0) a = 8'(1 << $urandom_range(0, 4));
          if ($urandom_range(0, 3) == 0) s = STROBE_SOL;
          send_item(REQ_AUX, a, 1'b0, '0);
          send_item(REQ_STROBE, s | STROBE_BIT, 1'b0, '0);
          send_item(REQ_STROBE, f & ~STROBE_BIT, 1'b0, '0);
          sent += 3;
        end
        MODE_LED: begin
          pick = $urandom_range(0, 2);
          if (pick == 0) a = AUX_RESYNC;
          else if (pick == 1) a = a | READ_IDLE;
          pick = $urandom_range(0, 9);
          if (pick < 5) s = STROBE_LAMP;
          else if (pick < 7) s = STROBE_SOL;
          send_item(REQ_AUX, a, 1'b0, '0);
          send_item(REQ_STROBE, s, 1'b0, '0);
          sent += 2;
        end
        MODE_LED2: begin
          if ($urandom_range(0, 9) < 3) begin
            send_item(REQ_AUX, a, 1'b0, '0);
            sent++;
          end
          send_item(REQ_STROBE, s | STROBE_BIT, 1'b0, '0);
          send_item(REQ_STROBE, f & ~STROBE_BIT, 1'b0, '0);
          sent += 2;
        end
        default: begin
          send_item(REQ_AUX, a, 1'b0, '0);
          send_item(REQ_STROBE, s, 1'b0, '0);
          sent += 2;
        end
      endcase
    end
  endtask

  task automatic report(input string what, input port_write_t e, input port_write_t g);
    errors++;
    if (errors <= 10) begin
      $display("tb: %s: exp kind %0d pl %0d grp %0d col %0d lamp %0d val %02h last %0b",
               what, e.w.kind, e.w.plane, e.w.group, e.w.column, e.w.lamp_column,
               e.w.value, e.last);
      $display("tb: %s: got kind %0d pl %0d grp %0d col %0d lamp %0d val %02h last %0b",
               what, g.w.kind, g.w.plane, g.w.group, g.w.column, g.w.lamp_column,
               g.w.value, g.last);
    end
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    port_write_t got;
    port_write_t exp_w;
    if (!rst && m_tvalid && m_tready) begin
      got.w.kind        = m_tuser;
      got.w.plane       = m_tdata[1:0];
      got.w.group       = m_tdata[3:2];
      got.w.column      = m_tdata[6:4];
      got.w.lamp_column = m_tdata[12:7];
      got.w.value       = m_tdata[20:13];
      got.last          = m_tlast;
      if (pending_writes.size() == 0) begin
        report("unexpected transaction", '0, got);
      end else begin
        exp_w = pending_writes.pop_front();
        if (exp_w != got || m_tdata[23:21] != 3'd0) report("mismatch", exp_w, got);
      end
    end
  end

  initial begin
    logic [2:0] phase_mode [12];
    int         phase_len;
    int         sent;
    bit         wrapped;

    phase_mode = '{MODE_T1, MODE_T2, MODE_LED, MODE_AUX,
                   MODE_T1S, MODE_SPARE7, MODE_T2, MODE_LED2,
                   MODE_T1, MODE_LED, MODE_SPARE6, MODE_LED2};

    cur_mode    = MODE_AUX;
    aux_byte    = '0;
    prev_strobe = '0;
    col_ptr     = '0;
    frame       = '0;
    foreach (ring[i]) ring[i] = '0;

    // directed table
    stim_rows.push_back(known_row(REQ_READ, 8'h00, KIND_READ, 6'd0, READ_IDLE));
    stim_rows.push_back(plain_row(REQ_AUX, 8'hff));
    stim_rows.push_back(known_row(REQ_STROBE, 8'h00, KIND_SOL, 6'd0, 8'hff));
    stim_rows.push_back(plain_row(REQ_NONE, 8'ha5));
    stim_rows.push_back(known_row(REQ_READ, 8'hff, KIND_READ, 6'd0, READ_IDLE));
    stim_rows.push_back(mode_row(MODE_T1));
    stim_rows.push_back(plain_row(REQ_AUX, 8'h10));
    stim_rows.push_back(known_row(REQ_STROBE, 8'h80, KIND_SOL, 6'd0, 8'h00));
    stim_rows.push_back(plain_row(REQ_AUX, 8'h7f));
    stim_rows.push_back(known_row(REQ_STROBE, 8'h38, KIND_SOL, 6'd0, 8'h07));
    stim_rows.push_back(plain_row(REQ_STROBE, 8'ha0));
    stim_rows.push_back(known_row(REQ_READ, 8'h00, KIND_READ, 6'd0, 8'h7f));
    stim_rows.push_back(plain_row(REQ_STROBE, 8'h00));
    stim_rows.push_back(plain_row(REQ_STROBE, 8'h80));
    stim_rows.push_back(plain_row(REQ_STROBE, 8'h00));
    stim_rows.push_back(plain_row(REQ_STROBE, 8'h80));
    stim_rows.push_back(plain_row(REQ_AUX, 8'hff));
    stim_rows.push_back(plain_row(REQ_STROBE, 8'h00));
    stim_rows.push_back(plain_row(REQ_STROBE, 8'h80));
    stim_rows.push_back(mode_row(MODE_T1S));
    stim_rows.push_back(known_row(REQ_STROBE, STROBE_SOL, KIND_SOL, 6'd0, 8'hff));
    stim_rows.push_back(mode_row(MODE_T2));
    stim_rows.push_back(plain_row(REQ_AUX, 8'h01));
    stim_rows.push_back(plain_row(REQ_STROBE, 8'h00));
    stim_rows.push_back(plain_row(REQ_STROBE, STROBE_SOL));
    stim_rows.push_back(mode_row(MODE_LED));
    stim_rows.push_back(plain_row(REQ_AUX, 8'h40));
    stim_rows.push_back(plain_row(REQ_STROBE, 8'h00));
    stim_rows.push_back(plain_row(REQ_AUX, AUX_RESYNC));
    stim_rows.push_back(known_row(REQ_STROBE, STROBE_LAMP, KIND_LAMP, 6'd15, AUX_RESYNC));
    stim_rows.push_back(known_row(REQ_STROBE, STROBE_LAMP, KIND_LAMP, 6'd11, AUX_RESYNC));
    stim_rows.push_back(known_row(REQ_STROBE, STROBE_SOL, KIND_SOL, 6'd0, AUX_RESYNC));
    stim_rows.push_back(mode_row(MODE_LED2));
    stim_rows.push_back(plain_row(REQ_AUX, 8'hff));
    stim_rows.push_back(known_row(REQ_STROBE, 8'hff, KIND_LAMP, 6'd12, 8'hff));
    stim_rows.push_back(mode_row(MODE_SPARE7));
    stim_rows.push_back(plain_row(REQ_AUX, 8'h00));
    stim_rows.push_back(known_row(REQ_STROBE, 8'hff, KIND_SOL, 6'd0, 8'h00));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle_pct  = 36;
    sink_idle_pct = 70;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_MODE) set_mode(stim_rows[i].data[2:0]);
      else send_item(stim_rows[i].req, stim_rows[i].data, stim_rows[i].known, stim_rows[i].res);
    end

    // random streams, one display mode per phase
    for (int p = 0; p < 12; p++) begin
      if (p == 4) begin
        src_idle_pct  = 70;
        sink_idle_pct = 36;
      end else if (p == 8) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      set_mode(phase_mode[p]);
      // long led2 phase walks the lamp columns through the wrap
      phase_len = (p == 11) ? 40 : 4;
      wrapped = (p != 11);
      sent = 0;
      while (sent < phase_len || !wrapped) begin
        random_burst(phase_mode[p], sent);
        if (col_ptr == '0) wrapped = 1'b1;
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
